FILE: hw/rtl/cdes_pkg.sv
// ============================================================================
// Civil date to epoch seconds: shared package
// Holds the item type that passes between the front and back parts, the
// calendar tables and the arithmetic constants of the conversion.
// ============================================================================
package cdes_pkg;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Character and field counts.
    localparam int DATE_CHARS = 8;
    localparam int HOUR_CHARS = 2;
    localparam int ALL_CHARS  = DATE_CHARS + HOUR_CHARS;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Field widths.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 7;
    localparam int STEP_W  = 16;
    localparam int SECS_W  = 39;

    // Division of the shifted year (below 10400) by 100 through a reciprocal.
    localparam int          RECIP_100_SHIFT = 19;
    localparam int          RECIP_100       = 5243;
    localparam int          PROD_W          = 27;

    // Day count bias: days from 0000-03-01 of the shifted calendar to the epoch.
    localparam int          DAY_BIAS      = 865565;
    localparam int          SECS_PER_DAY  = 86400;
    localparam int          SECS_PER_HOUR = 3600;

    // One parsed transaction as it waits in the queue.
    typedef struct packed {
        logic                ok;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [STEP_W-1:0]   step;
    } t_cdes_item;

    // True for an ASCII decimal digit.
    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Length of a month in a common year.
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                 len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:              len = 5'd31;
        endcase
        return len;
    endfunction

    // Day of the shifted year (starting in March) on which a month begins.
    function automatic logic [8:0] f_month_base(input logic [MONTH_W-1:0] m);
        logic [8:0] base;
        case (m)
            4'd3:    base = 9'd0;
            4'd4:    base = 9'd31;
            4'd5:    base = 9'd61;
            4'd6:    base = 9'd92;
            4'd7:    base = 9'd122;
            4'd8:    base = 9'd153;
            4'd9:    base = 9'd184;
            4'd10:   base = 9'd214;
            4'd11:   base = 9'd245;
            4'd12:   base = 9'd275;
            4'd1:    base = 9'd306;
            4'd2:    base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

FILE: hw/rtl/civil_date_to_epoch_seconds_unit.sv
// ============================================================================
// Civil date to epoch seconds: top level
// Converts an ASCII YYYYMMDD date, an ASCII run hour and a step in hours to
// signed seconds since 1970-01-01 UTC on the proleptic Gregorian calendar.
// ============================================================================
// The unit takes one transaction per clock cycle while it does not stall,
// and gives one result per transaction, in order. A transaction passes
// through the front register, which parses and validates the characters,
// then the queue and then the back pipeline. The back pipeline has four
// stages, the last of which is the output register, and its day-count
// multiply and seconds multiply each have a stage of their own.
// A four-entry queue between the two parts lets the input keep flowing for
// a few transactions while the output is stalled. The result is flagged
// invalid, with zero seconds, when any character is not a decimal digit, the
// month lies outside 1 to 12, or the day does not exist in that month; the
// run hour is not range checked.
module civil_date_to_epoch_seconds_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_date_char_0,
    input  logic [7:0]                        i_date_char_1,
    input  logic [7:0]                        i_date_char_2,
    input  logic [7:0]                        i_date_char_3,
    input  logic [7:0]                        i_date_char_4,
    input  logic [7:0]                        i_date_char_5,
    input  logic [7:0]                        i_date_char_6,
    input  logic [7:0]                        i_date_char_7,
    input  logic [7:0]                        i_hour_char_0,
    input  logic [7:0]                        i_hour_char_1,
    input  logic [cdes_pkg::STEP_W-1:0]       i_step_hours,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_valid_res,
    output logic signed [cdes_pkg::SECS_W-1:0] o_epoch_seconds
);

    logic [cdes_pkg::ALL_CHARS-1:0][7:0] w_chars;
    logic                                w_front_valid;
    cdes_pkg::t_cdes_item                w_front_item;
    logic                                w_queue_full;
    logic                                w_queue_valid;
    cdes_pkg::t_cdes_item                w_queue_item;
    logic                                w_pop;

    // Characters gathered in field order.
    assign w_chars[0] = i_date_char_0;
    assign w_chars[1] = i_date_char_1;
    assign w_chars[2] = i_date_char_2;
    assign w_chars[3] = i_date_char_3;
    assign w_chars[4] = i_date_char_4;
    assign w_chars[5] = i_date_char_5;
    assign w_chars[6] = i_date_char_6;
    assign w_chars[7] = i_date_char_7;
    assign w_chars[8] = i_hour_char_0;
    assign w_chars[9] = i_hour_char_1;

    // Parsing and validation.
    cdes_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_chars      (w_chars),
        .i_step_hours (i_step_hours),
        .o_valid      (w_front_valid),
        .o_item       (w_front_item),
        .i_full       (w_queue_full)
    );

    // Decoupling queue.
    cdes_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .i_push_item  (w_front_item),
        .o_full       (w_queue_full),
        .o_valid      (w_queue_valid),
        .o_item       (w_queue_item),
        .i_pop        (w_pop)
    );

    // Seconds computation.
    cdes_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_queue_valid),
        .i_item          (w_queue_item),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_valid_res     (o_valid_res),
        .o_epoch_seconds (o_epoch_seconds)
    );

endmodule

FILE: hw/rtl/cdes_front.sv
// ============================================================================
// Civil date to epoch seconds: front part
// Accepts a transaction, checks every character for a digit, forms the year,
// month, day and hour values and validates the date, then offers the parsed
// item to the queue.
// ============================================================================
module cdes_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [cdes_pkg::ALL_CHARS-1:0][7:0] i_chars,
    input  logic [cdes_pkg::STEP_W-1:0]     i_step_hours,
    output logic                            o_valid,
    output cdes_pkg::t_cdes_item            o_item,
    input  logic                            i_full
);

    logic                         r_valid;
    cdes_pkg::t_cdes_item         r_item;
    cdes_pkg::t_cdes_item         n_item;
    logic                         w_ready;
    logic [cdes_pkg::ALL_CHARS-1:0] w_is_digit;
    logic [cdes_pkg::ALL_CHARS-1:0][3:0] w_dv;
    logic [6:0]                   w_cent;
    logic [6:0]                   w_yr2;
    logic [6:0]                   w_month;
    logic [6:0]                   w_day;
    logic                         w_leap;
    logic [cdes_pkg::DAY_W-1:0]   w_lim;
    logic                         w_month_ok;
    logic                         w_day_ok;

    // Digit classification; the low nibble of an ASCII digit is its value.
    always_comb begin
        for (int i = 0; i < cdes_pkg::ALL_CHARS; i++) begin
            w_is_digit[i] = cdes_pkg::f_is_digit(i_chars[i]);
            w_dv[i]       = i_chars[i][3:0];
        end
    end

    // Two-digit values and the date checks.
    always_comb begin
        w_cent     = 7'(w_dv[0]) * 7'd10 + 7'(w_dv[1]);
        w_yr2      = 7'(w_dv[2]) * 7'd10 + 7'(w_dv[3]);
        w_month    = 7'(w_dv[4]) * 7'd10 + 7'(w_dv[5]);
        w_day      = 7'(w_dv[6]) * 7'd10 + 7'(w_dv[7]);
        // A year divisible by 4 but not by 100, or a whole century divisible by 4.
        w_leap     = ((w_yr2[1:0] == 2'd0) && (w_yr2 != 7'd0))
                     || ((w_yr2 == 7'd0) && (w_cent[1:0] == 2'd0));
        w_month_ok = w_month inside {[7'd1:7'd12]};
        w_lim      = cdes_pkg::f_month_len(w_month[3:0])
                     + cdes_pkg::DAY_W'((w_month[3:0] == 4'd2) && w_leap);
        w_day_ok   = (w_day != 7'd0) && (w_day <= 7'(w_lim));
    end

    // Parsed item.
    always_comb begin
        n_item.ok    = (&w_is_digit) && w_month_ok && w_day_ok;
        n_item.year  = cdes_pkg::YEAR_W'(w_cent) * cdes_pkg::YEAR_W'(100)
                       + cdes_pkg::YEAR_W'(w_yr2);
        n_item.month = w_month[3:0];
        n_item.day   = w_day[4:0];
        n_item.hour  = 7'(w_dv[8]) * 7'd10 + 7'(w_dv[9]);
        n_item.step  = i_step_hours;
    end

    // The front register frees itself whenever the queue has room.
    assign w_ready = !r_valid || !i_full;
    assign o_stall = !w_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: hw/rtl/cdes_queue.sv
// ============================================================================
// Civil date to epoch seconds: item queue
// A short first-in first-out queue of parsed items between the front and
// back parts, so that either side may stall on its own.
// ============================================================================
module cdes_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push_valid,
    input  cdes_pkg::t_cdes_item  i_push_item,
    output logic                  o_full,
    output logic                  o_valid,
    output cdes_pkg::t_cdes_item  o_item,
    input  logic                  i_pop
);

    cdes_pkg::t_cdes_item                 r_mem [cdes_pkg::QUEUE_DEPTH];
    logic [cdes_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [cdes_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [cdes_pkg::QUEUE_CNT_W-1:0]     r_count;
    logic [cdes_pkg::QUEUE_PTR_W-1:0]     n_wr_ptr;
    logic [cdes_pkg::QUEUE_PTR_W-1:0]     n_rd_ptr;
    logic                                 w_push;
    logic                                 w_pop;

    assign o_full  = (r_count == cdes_pkg::QUEUE_CNT_W'(cdes_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push_valid && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointer advance with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = (r_wr_ptr == cdes_pkg::QUEUE_PTR_W'(cdes_pkg::QUEUE_DEPTH - 1))
                   ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == cdes_pkg::QUEUE_PTR_W'(cdes_pkg::QUEUE_DEPTH - 1))
                   ? '0 : r_rd_ptr + 1'b1;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cdes_pkg::QUEUE_CNT_W'(cdes_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    // A lone push raises the fill count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue push not counted");

    // A lone pop lowers the fill count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue pop not counted");

endmodule

FILE: hw/rtl/cdes_back.sv
// ============================================================================
// Civil date to epoch seconds: back part
// A four-stage pipeline that turns a parsed item into seconds since the
// epoch: shifted year and day of year, day count, scaling to seconds, and
// the final sum in the output register.
// ============================================================================
module cdes_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  cdes_pkg::t_cdes_item              i_item,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_valid_res,
    output logic signed [cdes_pkg::SECS_W-1:0] o_epoch_seconds
);

    // Stage valid flags and per-stage readiness.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // Stage 1: shifted year, its reciprocal product, day of year, hours.
    logic                               r1_ok;
    logic [cdes_pkg::YEAR_W-1:0]        r1_yy;
    logic [cdes_pkg::PROD_W-1:0]        r1_prod;
    logic [8:0]                         r1_doy;
    logic [16:0]                        r1_hrs;
    logic [cdes_pkg::YEAR_W-1:0]        n1_yy;

    // Stage 2: unbiased day count.
    logic                               r2_ok;
    logic [21:0]                        r2_days_pos;
    logic [16:0]                        r2_hrs;
    logic [6:0]                         w_c100;
    logic [21:0]                        n2_days_pos;

    // Stage 3: seconds of the day count and of the hours.
    logic                               r3_ok;
    logic signed [cdes_pkg::SECS_W-1:0] r3_day_secs;
    logic [27:0]                        r3_hour_secs;
    logic signed [22:0]                 w_days;

    // Stage 4: output register.
    logic                               r4_ok;
    logic signed [cdes_pkg::SECS_W-1:0] r4_secs;

    // Each stage moves on when it is empty or the next one moves on.
    assign w_rdy4 = !r_v4 || !i_stall;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_pop  = i_valid && w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: January and February count with the previous year.
    assign n1_yy = i_item.year + cdes_pkg::YEAR_W'(400)
                   - cdes_pkg::YEAR_W'(i_item.month <= 4'd2);

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_ok   <= i_item.ok;
            r1_yy   <= n1_yy;
            r1_prod <= cdes_pkg::PROD_W'(n1_yy)
                       * cdes_pkg::PROD_W'(cdes_pkg::RECIP_100);
            r1_doy  <= cdes_pkg::f_month_base(i_item.month)
                       + 9'(i_item.day) - 9'd1;
            r1_hrs  <= 17'(i_item.hour) + 17'(i_item.step);
        end
    end

    // Stage 2: days = 365 y + y/4 - y/100 + y/400 + day of year.
    assign w_c100 = 7'(r1_prod[cdes_pkg::PROD_W-1:cdes_pkg::RECIP_100_SHIFT]);
    assign n2_days_pos = 22'(r1_yy) * 22'd365 + 22'(r1_yy[cdes_pkg::YEAR_W-1:2])
                         - 22'(w_c100) + 22'(w_c100[6:2]) + 22'(r1_doy);

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r2_ok       <= r1_ok;
            r2_days_pos <= n2_days_pos;
            r2_hrs      <= r1_hrs;
        end
    end

    // Stage 3: move the day count to the epoch and scale to seconds.
    assign w_days = $signed({1'b0, r2_days_pos}) - 23'(cdes_pkg::DAY_BIAS);

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r3_ok        <= r2_ok;
            r3_day_secs  <= cdes_pkg::SECS_W'(w_days)
                            * $signed(cdes_pkg::SECS_W'(cdes_pkg::SECS_PER_DAY));
            r3_hour_secs <= 28'(r2_hrs) * 28'(cdes_pkg::SECS_PER_HOUR);
        end
    end

    // Stage 4: final sum, forced to zero for an invalid date.
    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r4_ok   <= r3_ok;
            r4_secs <= r3_ok ? (r3_day_secs + $signed({11'd0, r3_hour_secs})) : '0;
        end
    end

    assign o_valid         = r_v4;
    assign o_valid_res     = r4_ok;
    assign o_epoch_seconds = r4_secs;

    // An invalid result always carries zero seconds.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r4_ok) |-> (r4_secs == '0))
        else $error("invalid result with non-zero seconds");

endmodule

FILE: test/tb_civil_date_to_epoch_seconds_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the civil date to epoch seconds unit
// Drives ASCII dates, run hours and steps through the valid/stall handshake
// with random idling on both sides. A scoreboard predicts each conversion on
// the proleptic Gregorian calendar and checks the results in order.
// ----------------------------------------------------------------------------

// Scoreboard: predicts the seconds for each accepted transaction and checks
// every result against the oldest prediction.
class epoch_scoreboard;

    typedef struct {
        bit                                  ok;
        logic signed [cdes_pkg::SECS_W-1:0] secs;
    } t_epoch_result;

    t_epoch_result expected_epochs[$];
    int            failures = 0;
    int            reported = 0;

    // Length of a month, February taking 29 days in a leap year.
    static function int unsigned days_in_month(int unsigned y, int unsigned m);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Reads a run of ASCII decimal digits; any other character fails it.
    function bit read_number(bit [9:0][7:0] ch, int first, int count,
                             output int unsigned value);
        value = 0;
        for (int k = first; k < first + count; k++) begin
            if (ch[k] < cdes_pkg::CHAR_ZERO || ch[k] > cdes_pkg::CHAR_NINE)
                return 1'b0;
            value = value * 10 + (ch[k] - cdes_pkg::CHAR_ZERO);
        end
        return 1'b1;
    endfunction

    // Converts one transaction into its expected result.
    function t_epoch_result civil_to_epoch(bit [9:0][7:0] ch, bit [15:0] step);
        t_epoch_result res;
        int unsigned   y, m, d, h;
        bit            ok;
        longint        shifted_y, era, yoe, mp, doy, doe, days, total;
        ok = read_number(ch, 0, 4, y);
        ok = read_number(ch, 4, 2, m) && ok;
        ok = read_number(ch, 6, 2, d) && ok;
        ok = read_number(ch, 8, 2, h) && ok;
        if (ok && (m < 1 || m > 12))
            ok = 1'b0;
        if (ok && (d < 1 || d > days_in_month(y, m)))
            ok = 1'b0;
        res.ok   = ok;
        res.secs = '0;
        if (ok) begin
            // Count days in 400-year eras from a year that starts in March.
            shifted_y = longint'(y) + 400 - ((m <= 2) ? 1 : 0);
            era       = shifted_y / 400;
            yoe       = shifted_y - era * 400;
            mp        = (longint'(m) + 9) % 12;
            doy       = (153 * mp + 2) / 5 + longint'(d) - 1;
            doe       = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days      = era * 146097 + doe - 719468 - 146097;
            total     = days * 86400 + longint'(h) * 3600 + longint'(step) * 3600;
            res.secs  = total[cdes_pkg::SECS_W-1:0];
        end
        return res;
    endfunction

    function void note_request(bit [9:0][7:0] ch, bit [15:0] step);
        expected_epochs.push_back(civil_to_epoch(ch, step));
    endfunction

    function void check_result(logic ok, logic signed [cdes_pkg::SECS_W-1:0] secs);
        t_epoch_result exp_res;
        if (expected_epochs.size() == 0) begin
            failures++;
            if (reported < 10) begin
                reported++;
                $display("Unexpected result: valid_res=%0b seconds=%0d", ok, secs);
            end
            return;
        end
        exp_res = expected_epochs.pop_front();
        if (ok !== exp_res.ok || secs !== exp_res.secs) begin
            failures++;
            if (reported < 10) begin
                reported++;
                $display("Mismatch: expected valid_res=%0b seconds=%0d, got %0b %0d",
                         exp_res.ok, exp_res.secs, ok, secs);
            end
        end
    endfunction

    function int outstanding();
        return expected_epochs.size();
    endfunction

endclass

module tb_civil_date_to_epoch_seconds_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_CHUNKS = 8;
    localparam int CHUNK_ITEMS = 115;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_valid = 1'b0;
    logic                                 o_stall;
    logic [7:0]                           i_date_char_0 = '0;
    logic [7:0]                           i_date_char_1 = '0;
    logic [7:0]                           i_date_char_2 = '0;
    logic [7:0]                           i_date_char_3 = '0;
    logic [7:0]                           i_date_char_4 = '0;
    logic [7:0]                           i_date_char_5 = '0;
    logic [7:0]                           i_date_char_6 = '0;
    logic [7:0]                           i_date_char_7 = '0;
    logic [7:0]                           i_hour_char_0 = '0;
    logic [7:0]                           i_hour_char_1 = '0;
    logic [cdes_pkg::STEP_W-1:0]          i_step_hours = '0;
    logic                                 o_valid;
    logic                                 i_stall = 1'b0;
    logic                                 o_valid_res;
    logic signed [cdes_pkg::SECS_W-1:0]   o_epoch_seconds;

    epoch_scoreboard sb = new();
    int              cycle_count = 0;
    bit              send_calm = 1'b0;
    bit              recv_calm = 1'b0;
    int unsigned     corner_years[7] = '{0, 1, 1900, 1969, 1970, 2000, 9999};

    civil_date_to_epoch_seconds_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_date_char_0   (i_date_char_0),
        .i_date_char_1   (i_date_char_1),
        .i_date_char_2   (i_date_char_2),
        .i_date_char_3   (i_date_char_3),
        .i_date_char_4   (i_date_char_4),
        .i_date_char_5   (i_date_char_5),
        .i_date_char_6   (i_date_char_6),
        .i_date_char_7   (i_date_char_7),
        .i_hour_char_0   (i_hour_char_0),
        .i_hour_char_1   (i_hour_char_1),
        .i_step_hours    (i_step_hours),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_valid_res     (o_valid_res),
        .o_epoch_seconds (o_epoch_seconds)
    );

    // Clock with a period of four time units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Note every accepted input transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_request({i_hour_char_1, i_hour_char_0,
                             i_date_char_7, i_date_char_6, i_date_char_5, i_date_char_4,
                             i_date_char_3, i_date_char_2, i_date_char_1, i_date_char_0},
                            i_step_hours);
    end

    // Check every accepted result transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_valid_res, o_epoch_seconds);
    end

    // Give up if the run hangs.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Builds the ten characters of a date and hour from numbers.
    function automatic bit [9:0][7:0] date_chars(int unsigned y, int unsigned m,
                                                 int unsigned d, int unsigned h);
        bit [9:0][7:0] ch;
        ch[0] = cdes_pkg::CHAR_ZERO + 8'(y / 1000 % 10);
        ch[1] = cdes_pkg::CHAR_ZERO + 8'(y / 100 % 10);
        ch[2] = cdes_pkg::CHAR_ZERO + 8'(y / 10 % 10);
        ch[3] = cdes_pkg::CHAR_ZERO + 8'(y % 10);
        ch[4] = cdes_pkg::CHAR_ZERO + 8'(m / 10 % 10);
        ch[5] = cdes_pkg::CHAR_ZERO + 8'(m % 10);
        ch[6] = cdes_pkg::CHAR_ZERO + 8'(d / 10 % 10);
        ch[7] = cdes_pkg::CHAR_ZERO + 8'(d % 10);
        ch[8] = cdes_pkg::CHAR_ZERO + 8'(h / 10 % 10);
        ch[9] = cdes_pkg::CHAR_ZERO + 8'(h % 10);
        return ch;
    endfunction

    // Offers one transaction after a random gap and holds it until accepted.
    task automatic drive_conversion(bit [9:0][7:0] ch, bit [15:0] step);
        int gap;
        gap = draw_wait(send_calm);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_date_char_0 = ch[0];
        i_date_char_1 = ch[1];
        i_date_char_2 = ch[2];
        i_date_char_3 = ch[3];
        i_date_char_4 = ch[4];
        i_date_char_5 = ch[5];
        i_date_char_6 = ch[6];
        i_date_char_7 = ch[7];
        i_hour_char_0 = ch[8];
        i_hour_char_1 = ch[9];
        i_step_hours  = step;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_date(int unsigned y, int unsigned m, int unsigned d,
                             int unsigned h, bit [15:0] step);
        drive_conversion(date_chars(y, m, d, h), step);
    endtask

    // Sends a date with one character replaced.
    task automatic send_corrupted(int pos, bit [7:0] c);
        bit [9:0][7:0] ch;
        ch      = date_chars(2024, 6, 15, 12);
        ch[pos] = c;
        drive_conversion(ch, 16'd5);
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed dates with random content, the rest broken or noise.
    task automatic send_random_conversion();
        bit [9:0][7:0] ch;
        bit [15:0]     step;
        int unsigned   y, m, d, h, kind;
        kind = $urandom_range(0, 99);
        y    = ($urandom_range(0, 9) == 0) ? corner_years[$urandom_range(0, 6)]
                                           : $urandom_range(0, 9999);
        m    = $urandom_range(1, 12);
        d    = $urandom_range(1, sb.days_in_month(y, m));
        h    = $urandom_range(0, 1) ? $urandom_range(0, 23) : $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       step = 16'd0;
            1:       step = 16'($urandom_range(0, 48));
            2:       step = 16'($urandom);
            default: step = 16'hFFFF;
        endcase
        if (kind >= 70 && kind < 80) begin
            // Numerically broken date.
            case ($urandom_range(0, 3))
                0:       d = 0;
                1:       d = $urandom_range(sb.days_in_month(y, m) + 1, 99);
                2:       m = 0;
                default: m = $urandom_range(13, 99);
            endcase
        end
        ch = date_chars(y, m, d, h);
        if (kind >= 80 && kind < 90) begin
            // One character replaced, often just outside the digit range.
            case ($urandom_range(0, 2))
                0:       ch[$urandom_range(0, 9)] = 8'h2F;
                1:       ch[$urandom_range(0, 9)] = 8'h3A;
                default: ch[$urandom_range(0, 9)] = 8'($urandom);
            endcase
        end else if (kind >= 90) begin
            for (int k = 0; k < 10; k++)
                ch[k] = 8'($urandom);
            step = 16'($urandom);
        end
        drive_conversion(ch, step);
    endtask

    // Result side: stalls for a random number of cycles before each result.
    initial begin
        int n;
        wait (i_rst_n);
        forever begin
            n = draw_wait(recv_calm);
            repeat (n) begin
                @(negedge i_clk);
                i_stall = 1'b1;
                @(posedge i_clk);
            end
            @(negedge i_clk);
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Main sequence: reset, directed cases, random chunks, drain.
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Epoch itself, the earliest and the latest representable instants.
        send_date(1970, 1, 1, 0, 16'd0);
        send_date(0, 1, 1, 0, 16'd0);
        send_date(9999, 12, 31, 99, 16'hFFFF);
        // Leap years: year zero, centuries and ordinary years.
        send_date(0, 2, 29, 12, 16'd1);
        send_date(1900, 2, 29, 0, 16'd0);
        send_date(2000, 2, 29, 0, 16'd0);
        send_date(2023, 2, 29, 0, 16'd0);
        send_date(2024, 2, 29, 23, 16'd48);
        // Month ends and out-of-range months and days.
        send_date(2024, 4, 30, 6, 16'd0);
        send_date(2024, 4, 31, 6, 16'd0);
        send_date(2024, 13, 1, 0, 16'd0);
        send_date(2024, 0, 15, 0, 16'd0);
        send_date(2024, 1, 0, 0, 16'd0);
        send_date(2024, 1, 32, 0, 16'd0);
        send_date(2024, 12, 31, 0, 16'd0);
        // Large run hour just before the epoch.
        send_date(1969, 12, 31, 99, 16'd0);
        // Non-digit characters: signs, a space, a letter, neighbours of the digits, 00 and FF.
        send_corrupted(0, 8'h20);
        send_corrupted(1, 8'h61);
        send_corrupted(3, 8'h3A);
        send_corrupted(4, 8'h2D);
        send_corrupted(6, 8'h2B);
        send_corrupted(7, 8'h2F);
        send_corrupted(8, 8'h00);
        send_corrupted(9, 8'hFF);

        // Hold off until the pipeline is empty.
        @(negedge i_clk);
        i_valid = 1'b0;
        wait_drained();

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            send_calm = (chunk % 3 == 1);
            recv_calm = (chunk % 4 == 2);
            for (int k = 0; k < CHUNK_ITEMS; k++)
                send_random_conversion();
            if (chunk == RANDOM_CHUNKS / 2) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                wait_drained();
            end
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
